FILE: hdl/mpfs_pkg.sv
// ----------------------------------------------------------------------------
// mpfs_pkg
// Shared constants for the page frame store streamer: panel defaults,
// request operation codes and panel command bytes.
// ----------------------------------------------------------------------------
package mpfs_pkg;

  localparam int PANEL_WIDTH_DEF  = 128;
  localparam int PANEL_HEIGHT_DEF = 64;

  // one 64-bit word per column, bit y is row y
  localparam int COL_W = 64;

  // request operation codes
  localparam logic [1:0] OP_DRAW = 2'd0;
  localparam logic [1:0] OP_FILL = 2'd1;
  localparam logic [1:0] OP_SEND = 2'd2;

  // panel command bytes
  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW   = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

endpackage

FILE: hdl/mono_page_framebuffer_streamer.sv
// ----------------------------------------------------------------------------
// mono_page_framebuffer_streamer
// One-bit frame store, one 64-bit word per column, with pixel draw, whole
// store fill and a page streamer that feeds a panel link.
// ----------------------------------------------------------------------------
// Usage
//   Request channel (req_valid/req_ready): operation, pixel_x, pixel_y,
//   pixel_color, page_index. Draw and fill give no response items; a send
//   gives three command items (page, column low, column high) and then
//   ceil(PANEL_WIDTH/8) data items of eight column bytes, last one marked.
//   Response channel (rsp_valid/rsp_ready): is_data, payload, last_of_page,
//   held in an output register so the block runs on while an item waits.
//   Throughput: back-to-back draws go in one per cycle while the sequencer
//   is idle (read, then merge and write back, with forwarding when the
//   same column is hit twice in a row). Fill clears the per-column valid
//   bits and records the fill colour. A send holds the request channel
//   through its commands and data words, whose pace is set by the single
//   memory read port (one column per cycle while the assembled word is not
//   waiting, eight columns per word).
//   Fill and send wait while a draw write is still in flight.
//   Reset: frame reads as dark at once (valid bits cleared, no sweep).
//   Receiver stall: the streamer holds its assembled word and pauses reads.
// ----------------------------------------------------------------------------
module mono_page_framebuffer_streamer
  import mpfs_pkg::*;
#(
  parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [1:0]  operation,
  input  logic [7:0]  pixel_x,
  input  logic [7:0]  pixel_y,
  input  logic [15:0] pixel_color,
  input  logic [2:0]  page_index,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic        is_data,
  output logic [63:0] payload,
  output logic        last_of_page
);

  localparam int CW     = (PANEL_WIDTH > 1) ? $clog2(PANEL_WIDTH) : 1;
  localparam int WORDS  = (PANEL_WIDTH + 7) / 8;
  localparam int WW     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int ISSUES = WORDS * 8;
  localparam int IW     = $clog2(ISSUES + 1);
  // rows at or beyond the panel height never light
  localparam logic [COL_W-1:0] ROW_MASK = (64'd1 << PANEL_HEIGHT) - 64'd1;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_CMD_PAGE = 5'b00010,
    S_CMD_LOW  = 5'b00100,
    S_CMD_HIGH = 5'b01000,
    S_DATA     = 5'b10000
  } state_t;

  state_t state;

  // frame store and per-column valid bits (invalid column reads as fill)
  logic [COL_W-1:0]       mem [PANEL_WIDTH];
  logic [PANEL_WIDTH-1:0] vld;
  logic                   fill_lit;
  logic [COL_W-1:0]       fill_word;

  logic [CW-1:0]    rd_addr;
  logic [COL_W-1:0] rd_data;
  logic             rd_vld;
  logic [COL_W-1:0] rd_word;

  // draw pipeline
  logic             s1_valid;
  logic [CW-1:0]    s1_col;
  logic [5:0]       s1_row;
  logic             s1_lit;
  logic             fwd_valid;
  logic [CW-1:0]    fwd_col;
  logic [COL_W-1:0] fwd_word;
  logic [COL_W-1:0] merge_base;
  logic [COL_W-1:0] merge_word;

  // page streamer
  logic [2:0]       page;
  logic [IW-1:0]    iss;
  logic [WW-1:0]    wcnt;
  logic             rd_pend;
  logic [2:0]       rd_lane;
  logic             rd_in;
  logic [63:0]      acc;
  logic             word_full;
  logic             issue;
  logic             xfer;
  logic [7:0]       col_byte;

  logic req_fire;
  logic draw_on_panel;
  logic load_ok;

  assign fill_word = fill_lit ? ROW_MASK : '0;

  // fill and send wait for an in-flight draw write
  assign req_ready = (state == S_IDLE) && (!s1_valid || (operation == OP_DRAW));
  assign req_fire  = req_valid && req_ready;

  assign draw_on_panel = ({1'b0, pixel_x} < 9'(PANEL_WIDTH)) &&
                         ({1'b0, pixel_y} < 9'(PANEL_HEIGHT));

  assign load_ok = !rsp_valid || rsp_ready;

  assign rd_addr = (state == S_DATA) ? iss[CW-1:0] : pixel_x[CW-1:0];
  assign rd_word = rd_vld ? rd_data : fill_word;

  // a write at the edge that captured this draw is not yet in rd_data
  assign merge_base = (fwd_valid && (fwd_col == s1_col)) ? fwd_word : rd_word;
  assign merge_word = s1_lit ? (merge_base | (64'd1 << s1_row))
                             : (merge_base & ~(64'd1 << s1_row));

  assign issue = (state == S_DATA) && (iss != IW'(ISSUES)) && !word_full &&
                 !(rd_pend && (rd_lane == 3'd7));
  assign xfer  = (state == S_DATA) && word_full && load_ok;

  assign col_byte = rd_in ? rd_word[{page, 3'b000} +: 8] : 8'h00;

  // synchronous memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      mem[s1_col] <= merge_word;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      fill_lit <= 1'b0;
    end else if (req_fire && (operation == OP_FILL)) begin
      vld      <= '0;
      fill_lit <= (pixel_color != 16'd0);
    end else if (s1_valid) begin
      vld[s1_col] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_vld <= vld[rd_addr];
  end

  // draw: capture, then merge and write back
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      s1_valid  <= req_fire && (operation == OP_DRAW) && draw_on_panel;
      fwd_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_col   <= pixel_x[CW-1:0];
    s1_row   <= pixel_y[5:0];
    s1_lit   <= (pixel_color != 16'd0);
    fwd_col  <= s1_col;
    fwd_word <= merge_word;
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      rd_pend   <= 1'b0;
      word_full <= 1'b0;
      iss       <= '0;
      wcnt      <= '0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      rd_pend <= issue;
      if (issue) begin
        iss <= iss + IW'(1);
      end
      if (rd_pend && (rd_lane == 3'd7)) begin
        word_full <= 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (req_fire && (operation == OP_SEND)) begin
            state     <= S_CMD_PAGE;
            iss       <= '0;
            wcnt      <= '0;
            word_full <= 1'b0;
          end
        end
        S_CMD_PAGE: begin
          if (load_ok) begin
            rsp_valid <= 1'b1;
            state     <= S_CMD_LOW;
          end
        end
        S_CMD_LOW: begin
          if (load_ok) begin
            rsp_valid <= 1'b1;
            state     <= S_CMD_HIGH;
          end
        end
        S_CMD_HIGH: begin
          if (load_ok) begin
            rsp_valid <= 1'b1;
            state     <= S_DATA;
          end
        end
        S_DATA: begin
          if (xfer) begin
            rsp_valid <= 1'b1;
            word_full <= 1'b0;
            wcnt      <= wcnt + WW'(1);
            if (wcnt == WW'(WORDS - 1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload side: no reset needed
  always_ff @(posedge clk) begin
    if (req_fire && (operation == OP_SEND)) begin
      page <= page_index;
    end

    if (issue) begin
      rd_lane <= iss[2:0];
      rd_in   <= (iss < IW'(PANEL_WIDTH));
    end

    if (rd_pend) begin
      acc[{rd_lane, 3'b000} +: 8] <= col_byte;
    end

    if (load_ok && (state == S_CMD_PAGE)) begin
      is_data      <= 1'b0;
      payload      <= {56'd0, CMD_PAGE_BASE + {5'd0, page}};
      last_of_page <= 1'b0;
    end else if (load_ok && (state == S_CMD_LOW)) begin
      is_data      <= 1'b0;
      payload      <= {56'd0, CMD_COL_LOW};
      last_of_page <= 1'b0;
    end else if (load_ok && (state == S_CMD_HIGH)) begin
      is_data      <= 1'b0;
      payload      <= {56'd0, CMD_COL_HIGH};
      last_of_page <= 1'b0;
    end else if (xfer) begin
      is_data      <= 1'b1;
      payload      <= acc;
      last_of_page <= (wcnt == WW'(WORDS - 1));
    end
  end

endmodule
